// ----- hdl/tcc_pkg.sv -----
// Shared types and constants for the text console cursor engine.
// Holds the geometry constants, character codes, command codes and the
// status and result structs used between controller, datapath and output stage.
package tcc_pkg;

	// screen geometry
	localparam int SCREEN_W   = 1024;
	localparam int SCREEN_H   = 768;
	localparam int CELL_SIZE  = 16;
	localparam int HEX_DIGITS = 6;

	// field and state widths
	localparam int CH_W       = 8;
	localparam int COL_W      = $clog2(SCREEN_W + CELL_SIZE);
	localparam int ROW_W      = 16;
	localparam int CNT_W      = 21;
	localparam int COLOR_W    = 24;
	localparam int LS_W       = 8;
	localparam int POS_X_W    = 10;
	localparam int ROWS_W     = 9;
	localparam int DIG_W      = $clog2(HEX_DIGITS + 1);
	localparam int DIG_IDX_W  = $clog2(HEX_DIGITS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int TDATA_W    = 96;

	// register reset values
	localparam logic [LS_W-1:0]    RST_LINE_SPACING = 8'd2;
	localparam logic [COLOR_W-1:0] RST_BACKGROUND   = 24'h0B1A1C;
	localparam logic [COLOR_W-1:0] RST_DEFAULT_FG   = 24'hFFFFFF;
	localparam logic [CNT_W-1:0]   RST_CAPACITY     = 21'd1048576;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_SPACING = 2'd0,
		CFG_BACKGROUND   = 2'd1,
		CFG_DEFAULT_FG   = 2'd2,
		CFG_CAPACITY     = 2'd3
	} cfg_idx_t;

	// character codes
	localparam logic [CH_W-1:0] CH_NUL    = 8'd0;
	localparam logic [CH_W-1:0] CH_BS     = 8'd8;
	localparam logic [CH_W-1:0] CH_TAB    = 8'd9;
	localparam logic [CH_W-1:0] CH_NL     = 8'd10;
	localparam logic [CH_W-1:0] CH_SPACE  = 8'd32;
	localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CH_W-1:0] CH_BSL    = 8'h5C;

	// result kinds
	localparam logic KIND_DRAW   = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	// controller to datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_ESC_OPEN,
		CMD_ESC_DIGIT,
		CMD_ESC_CLOSE,
		CMD_ESC_HOLD,
		CMD_REP_START,
		CMD_PLAIN_IN,
		CMD_PLAIN_REP,
		CMD_NEXT_LINE
	} cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic ch_zero;
		logic ch_bsl;
		logic ch_lparen;
		logic ch_rparen;
		logic ch_hex;
		logic eot;
		logic esc_bsl;
		logic esc_dig;
		logic dig_full;
		logic nl_pend;
		logic rep_active;
	} dp_stat_t;

	// output stage status seen by the controller
	typedef struct packed {
		logic pend_v;
		logic out_free;
	} out_stat_t;

	// one result item
	typedef struct packed {
		logic                      kind;
		logic [POS_X_W-1:0]        pos_x;
		logic signed [ROW_W-1:0]   pos_y;
		logic [CH_W-1:0]           glyph;
		logic [COLOR_W-1:0]        text_color;
		logic [COLOR_W-1:0]        fill_color;
		logic [ROWS_W-1:0]         scroll_rows;
	} res_t;

endpackage

// ----- hdl/tcc_dpath.sv -----
// Datapath of the cursor engine: config registers, cursor, held count, colors,
// escape parser storage and replay pointer. Executes one command per cycle.
// Depends on tcc_pkg.
module tcc_dpath
	import tcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [CH_W-1:0]       in_ch,
	input  logic                  in_eot,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dp_stat_t              stat,
	output logic                  emit,
	output res_t                  res
);

	localparam int RX_W = ROW_W + 2;
	localparam logic signed [RX_W-1:0] ROW_HI = RX_W'(2 ** (ROW_W - 1) - 1);
	localparam logic signed [RX_W-1:0] ROW_LO = -ROW_HI - RX_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_BSL,
		ESC_DIG
	} esc_mode_t;

	function automatic logic signed [ROW_W-1:0] sat_row(input logic signed [RX_W-1:0] v);
		logic signed [RX_W-1:0] r;
		r = v;
		if (v > ROW_HI)
			r = ROW_HI;
		else if (v < ROW_LO)
			r = ROW_LO;
		return r[ROW_W-1:0];
	endfunction

	function automatic logic signed [RX_W-1:0] row_ext(input logic signed [ROW_W-1:0] v);
		return $signed({{(RX_W-ROW_W){v[ROW_W-1]}}, v});
	endfunction

	function automatic logic is_hex(input logic [CH_W-1:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [3:0] hex_val(input logic [CH_W-1:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[8'h30:8'h39]})
			v = 4'(c - 8'h30);
		else if (c inside {[8'h41:8'h46]})
			v = 4'(c - 8'h37);
		else if (c inside {[8'h61:8'h66]})
			v = 4'(c - 8'h57);
		return v;
	endfunction

	// configuration
	logic [LS_W-1:0]    ls_q;
	logic [COLOR_W-1:0] bg_q;
	logic [CNT_W-1:0]   cap_q;

	// item and cursor state
	logic [CH_W-1:0]         ch_q;
	logic                    eot_q;
	logic [COL_W-1:0]        col_q, col_d;
	logic signed [ROW_W-1:0] row_q, row_d;
	logic [CNT_W-1:0]        held_q, held_d;
	logic [COLOR_W-1:0]      fg_q;
	logic                    nl_pend_q, nl_pend_d;

	// escape parser and replay pointer
	esc_mode_t           esc_q;
	logic [DIG_W-1:0]    dig_cnt_q;
	logic [COLOR_W-1:0]  esc_color_q;
	logic [CH_W-1:0]     esc_chars_q [HEX_DIGITS];
	logic                rep_bsl_q;
	logic [DIG_W-1:0]    rep_idx_q;
	logic [DIG_W-1:0]    rep_end_q;
	logic                rep_active_q;

	logic [CH_W-1:0]         rep_ch;
	logic [CH_W-1:0]         plain_ch;
	logic [ROWS_W-1:0]       lh;
	logic signed [RX_W-1:0]  lhx;
	logic signed [RX_W-1:0]  rowx;
	logic signed [ROW_W-1:0] nl_row1, nl_row2, bs_row;
	logic                    nl_hit;
	logic [COL_W-1:0]        col_nx;
	logic                    wrap;

	// replayed character: the opener first, then the held digits
	assign rep_ch = (rep_idx_q == '0) ? (rep_bsl_q ? CH_BSL : CH_LPAREN)
	              : esc_chars_q[DIG_IDX_W'(rep_idx_q - DIG_W'(1))];
	assign plain_ch = (cmd == CMD_PLAIN_REP) ? rep_ch : ch_q;

	// row arithmetic for line feed and backspace
	assign lh      = ROWS_W'(CELL_SIZE) + ROWS_W'(ls_q);
	assign lhx     = $signed({{(RX_W-ROWS_W){1'b0}}, lh});
	assign rowx    = row_ext(row_q);
	assign nl_row1 = sat_row(rowx + lhx);
	assign nl_hit  = (row_ext(nl_row1) + RX_W'(CELL_SIZE)) >= $signed(RX_W'(SCREEN_H));
	assign nl_row2 = sat_row(row_ext(nl_row1) - lhx);
	assign bs_row  = sat_row(rowx - lhx);

	// column advance and right-edge test
	assign col_nx = col_q + COL_W'(CELL_SIZE);
	assign wrap   = ({1'b0, col_nx} + (COL_W+1)'(CELL_SIZE)) >= (COL_W+1)'(SCREEN_W);

	// cursor, count and result for plain characters and line feeds
	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		held_d    = held_q;
		nl_pend_d = nl_pend_q;
		emit      = 1'b0;
		res.kind        = KIND_DRAW;
		res.pos_x       = POS_X_W'(col_q);
		res.pos_y       = row_q;
		res.glyph       = plain_ch;
		res.text_color  = fg_q;
		res.fill_color  = bg_q;
		res.scroll_rows = '0;
		case (cmd)
			CMD_PLAIN_IN, CMD_PLAIN_REP: begin
				case (plain_ch)
					CH_NL: begin
						if (held_q != CNT_MAX)
							held_d = held_q + CNT_W'(1);
						nl_pend_d = 1'b1;
					end
					CH_BS: begin
						if (held_q != '0) begin
							held_d = held_q - CNT_W'(1);
							if (col_q == '0) begin
								col_d = COL_W'(SCREEN_W - CELL_SIZE);
								row_d = bs_row;
							end else begin
								col_d = col_q - COL_W'(CELL_SIZE);
							end
							emit      = 1'b1;
							res.pos_x = POS_X_W'(col_d);
							res.pos_y = row_d;
							res.glyph = CH_SPACE;
						end
					end
					CH_TAB: begin
					end
					default: begin
						if (held_q < cap_q) begin
							held_d = held_q + CNT_W'(1);
							emit   = 1'b1;
							col_d  = col_nx;
							if (wrap)
								nl_pend_d = 1'b1;
						end
					end
				endcase
			end
			CMD_NEXT_LINE: begin
				nl_pend_d = 1'b0;
				col_d     = '0;
				if (nl_hit) begin
					row_d           = nl_row2;
					emit            = 1'b1;
					res.kind        = KIND_SCROLL;
					res.pos_x       = '0;
					res.pos_y       = '0;
					res.glyph       = '0;
					res.text_color  = '0;
					res.scroll_rows = lh;
				end else begin
					row_d = nl_row1;
				end
			end
			default: begin
			end
		endcase
	end

	// control and cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q         <= RST_LINE_SPACING;
			bg_q         <= RST_BACKGROUND;
			cap_q        <= RST_CAPACITY;
			fg_q         <= RST_DEFAULT_FG;
			col_q        <= '0;
			row_q        <= '0;
			held_q       <= '0;
			nl_pend_q    <= 1'b0;
			esc_q        <= ESC_IDLE;
			dig_cnt_q    <= '0;
			esc_color_q  <= '0;
			rep_bsl_q    <= 1'b0;
			rep_idx_q    <= '0;
			rep_end_q    <= '0;
			rep_active_q <= 1'b0;
		end else begin
			col_q     <= col_d;
			row_q     <= row_d;
			held_q    <= held_d;
			nl_pend_q <= nl_pend_d;
			case (cmd)
				CMD_ESC_OPEN: begin
					esc_q       <= ESC_DIG;
					dig_cnt_q   <= '0;
					esc_color_q <= '0;
				end
				CMD_ESC_DIGIT: begin
					esc_color_q <= {esc_color_q[COLOR_W-5:0], hex_val(ch_q)};
					dig_cnt_q   <= dig_cnt_q + DIG_W'(1);
				end
				CMD_ESC_CLOSE: begin
					fg_q  <= esc_color_q;
					esc_q <= ESC_IDLE;
				end
				CMD_ESC_HOLD: begin
					esc_q <= ESC_BSL;
				end
				CMD_REP_START: begin
					rep_bsl_q    <= (esc_q == ESC_BSL);
					rep_end_q    <= (esc_q == ESC_BSL) ? '0 : dig_cnt_q;
					rep_idx_q    <= '0;
					rep_active_q <= 1'b1;
					esc_q        <= ESC_IDLE;
				end
				CMD_PLAIN_REP: begin
					if (rep_idx_q == rep_end_q)
						rep_active_q <= 1'b0;
					else
						rep_idx_q <= rep_idx_q + DIG_W'(1);
				end
				default: begin
				end
			endcase
			// the user must write only while idle; the block itself does not enforce it
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_LINE_SPACING: ls_q  <= cfg_data[LS_W-1:0];
					CFG_BACKGROUND:   bg_q  <= cfg_data[COLOR_W-1:0];
					CFG_DEFAULT_FG:   fg_q  <= cfg_data[COLOR_W-1:0];
					CFG_CAPACITY:     cap_q <= cfg_data[CNT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// latched item and held escape digits
	always_ff @(posedge clk) begin
		if (cmd == CMD_LATCH) begin
			ch_q  <= in_ch;
			eot_q <= in_eot;
		end
		if (cmd == CMD_ESC_DIGIT)
			esc_chars_q[DIG_IDX_W'(dig_cnt_q)] <= ch_q;
	end

	// status to the controller
	assign stat.ch_zero    = (ch_q == CH_NUL);
	assign stat.ch_bsl     = (ch_q == CH_BSL);
	assign stat.ch_lparen  = (ch_q == CH_LPAREN);
	assign stat.ch_rparen  = (ch_q == CH_RPAREN);
	assign stat.ch_hex     = is_hex(ch_q);
	assign stat.eot        = eot_q;
	assign stat.esc_bsl    = (esc_q == ESC_BSL);
	assign stat.esc_dig    = (esc_q == ESC_DIG);
	assign stat.dig_full   = (dig_cnt_q == DIG_W'(HEX_DIGITS));
	assign stat.nl_pend    = nl_pend_q;
	assign stat.rep_active = rep_active_q;

endmodule

// ----- hdl/tcc_out.sv -----
// Output stage: a pending result register that holds the newest result until
// it is known whether it is the last of its item, then the output register.
// Depends on tcc_pkg.
module tcc_out
	import tcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               emit,
	input  res_t               res,
	input  logic               finish,
	output out_stat_t          stat,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);

	res_t pend_q;
	logic pend_v_q;
	res_t out_res_q;
	logic out_last_q;
	logic out_v_q;
	logic load;

	// the pending result moves out when a newer one arrives or the item ends
	assign load = (emit && pend_v_q) || finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			if (emit)
				pend_v_q <= 1'b1;
			else if (finish)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			pend_q <= res;
		if (load) begin
			out_res_q  <= pend_q;
			out_last_q <= finish;
		end
	end

	assign stat.pend_v   = pend_v_q;
	assign stat.out_free = !out_v_q || m_tready;

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_res_q.kind;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(TDATA_W - 91)'(0), out_res_q.scroll_rows, out_res_q.fill_color,
	                   out_res_q.text_color, out_res_q.glyph, out_res_q.pos_y,
	                   out_res_q.pos_x};

endmodule

// ----- hdl/tcc_ctrl.sv -----
// Controller of the cursor engine: walks one input item through escape
// parsing, replay of broken escapes, plain character handling and line feeds.
// Depends on tcc_pkg.
module tcc_ctrl
	import tcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  dp_stat_t  dstat,
	input  out_stat_t ostat,
	output cmd_t      cmd,
	output logic      finish
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FEED,
		S_CHAR,
		S_REP,
		S_WRAP,
		S_EOT,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	logic   from_rep_q, from_rep_d;
	logic   step_ok;
	state_t after_wrap;

	// a step that may produce a result needs room in the output stage
	assign step_ok = !ostat.pend_v || ostat.out_free;

	assign after_wrap = from_rep_q ? (dstat.rep_active ? S_REP : ret_q) : S_EOT;

	always_comb begin
		cmd        = CMD_NONE;
		finish     = 1'b0;
		state_d    = state_q;
		ret_d      = ret_q;
		from_rep_d = from_rep_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd     = CMD_LATCH;
					state_d = S_FEED;
				end
			end
			S_FEED: begin
				if (dstat.ch_zero) begin
					state_d = S_EOT;
				end else if (dstat.esc_bsl) begin
					if (dstat.ch_lparen) begin
						cmd     = CMD_ESC_OPEN;
						state_d = S_EOT;
					end else begin
						cmd     = CMD_REP_START;
						ret_d   = S_CHAR;
						state_d = S_REP;
					end
				end else if (dstat.esc_dig) begin
					if (!dstat.dig_full && dstat.ch_hex) begin
						cmd     = CMD_ESC_DIGIT;
						state_d = S_EOT;
					end else if (dstat.dig_full && dstat.ch_rparen) begin
						cmd     = CMD_ESC_CLOSE;
						state_d = S_EOT;
					end else begin
						// broken escape
						cmd     = CMD_REP_START;
						ret_d   = S_CHAR;
						state_d = S_REP;
					end
				end else begin
					state_d = S_CHAR;
				end
			end
			S_CHAR: begin
				if (dstat.ch_bsl) begin
					cmd     = CMD_ESC_HOLD;
					state_d = S_EOT;
				end else if (step_ok) begin
					cmd        = CMD_PLAIN_IN;
					from_rep_d = 1'b0;
					state_d    = S_WRAP;
				end
			end
			S_REP: begin
				if (step_ok) begin
					cmd        = CMD_PLAIN_REP;
					from_rep_d = 1'b1;
					state_d    = S_WRAP;
				end
			end
			S_WRAP: begin
				if (!dstat.nl_pend) begin
					state_d = after_wrap;
				end else if (step_ok) begin
					cmd     = CMD_NEXT_LINE;
					state_d = after_wrap;
				end
			end
			S_EOT: begin
				// end of string or a zero byte flushes a pending escape
				if ((dstat.eot || dstat.ch_zero) && (dstat.esc_bsl || dstat.esc_dig)) begin
					cmd     = CMD_REP_START;
					ret_d   = S_DONE;
					state_d = S_REP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!ostat.pend_v) begin
					state_d = S_IDLE;
				end else if (ostat.out_free) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			from_rep_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ret_q      <= ret_d;
			from_rep_q <= from_rep_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

// ----- hdl/text_console_cursor_engine.sv -----
// Top level of the text console cursor engine.
// Instantiates tcc_ctrl, tcc_dpath and tcc_out; depends on tcc_pkg.
//
//   channel  signals                               contents
//   s_       tvalid tready tdata[7:0] tlast        ch / end_of_text
//   m_       tvalid tready tdata[95:0] tuser tlast draw or scroll command / run_last
//   cfg_     we idx[1:0] data[23:0]                register writes
//
// Each item walks the controller states IDLE (latch), FEED, CHAR or REP, WRAP,
// EOT and DONE; escape characters and zero bytes go from FEED to EOT, a held
// backslash from CHAR to EOT, and each replayed escape character passes REP and
// WRAP. The controller steps one plain character at a time, taking items only in IDLE.
// Reset is asynchronous and needs no clearing pass.
// A stalled output holds the engine once its pending and output registers are full.
module text_console_cursor_engine
	import tcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [CH_W-1:0]       s_tdata,   // [7:0] ch
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [9:0] pos_x, [25:10] pos_y, [33:26] glyph, [57:34] text_color,
	// [81:58] fill_color, [90:82] scroll_rows, rest zero
	output logic [TDATA_W-1:0]    m_tdata,
	output logic                  m_tuser,   // [0] kind
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t      cmd;
	dp_stat_t  dstat;
	out_stat_t ostat;
	logic      emit;
	logic      finish;
	res_t      res;

	tcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.dstat    (dstat),
		.ostat    (ostat),
		.cmd      (cmd),
		.finish   (finish)
	);

	tcc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_ch    (s_tdata),
		.in_eot   (s_tlast),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.stat     (dstat),
		.emit     (emit),
		.res      (res)
	);

	tcc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.res      (res),
		.finish   (finish),
		.stat     (ostat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- hdl/tcc_checker.sv -----
// Port-level checks for the text console cursor engine, bound to the top level.
// Depends on tcc_pkg.
module tcc_checker
	import tcc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [TDATA_W-1:0]    m_tdata,
	input logic                  m_tuser,
	input logic                  m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output changed while stalled");

	// scroll commands carry no cell position, glyph or text color
	a_scroll_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[57:0] == 58'd0)
		else $error("scroll command with cell fields set");

	// draw commands carry no scroll height
	a_draw_rows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[90:82] == 9'd0)
		else $error("draw command with scroll rows set");

	// the engine is not ready again in the cycle after a transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (.*);

// ----- bench/text_console_cursor_engine_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for text_console_cursor_engine: feeds character transfers,
// predicts draw and scroll commands with its own cursor model, checks each one.
// Depends on tcc_pkg and the RTL of the engine.
module text_console_cursor_engine_tb;
	import tcc_pkg::*;

	localparam int IDLE_MAX  = 4;
	localparam int DRAIN_CYC = 32;
	localparam int HOLD_CYC  = 300;
	localparam int MSG_LIMIT = 30;
	localparam int ROW_MAX   = 32767;
	localparam int ROW_MIN   = -32768;
	localparam int HELD_MAX  = 2097151;

	// escape parser phases; digits held = phase - ESC_HEX0
	localparam int ESC_IDLE  = 0;
	localparam int ESC_SLASH = 1;
	localparam int ESC_HEX0  = 2;

	localparam logic [CH_W-1:0] CH_DIG0 = "0";
	localparam logic [CH_W-1:0] CH_DIG9 = "9";
	localparam logic [CH_W-1:0] CH_LO_A = "a";
	localparam logic [CH_W-1:0] CH_LO_F = "f";
	localparam logic [CH_W-1:0] CH_UP_A = "A";
	localparam logic [CH_W-1:0] CH_UP_F = "F";

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            eot;
	} key_t;

	typedef struct {
		logic               kind;
		logic [POS_X_W-1:0] x;
		logic [ROW_W-1:0]   y;
		logic [CH_W-1:0]    glyph;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] fill;
		logic [ROWS_W-1:0]  rows;
		logic               last;
	} screen_op_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [CH_W-1:0]       s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// bench control
	logic steady = 1'b0;
	logic press_go = 1'b0;
	logic rx_hold = 1'b0;
	int   send_gap;
	int   recv_gap;
	int   mism_cnt = 0;
	key_t typed_keys[$];

	// console model: registers and state
	logic [LS_W-1:0]    spacing = RST_LINE_SPACING;
	logic [COLOR_W-1:0] bg_reg = RST_BACKGROUND;
	logic [COLOR_W-1:0] fg_now = RST_DEFAULT_FG;
	logic [CNT_W-1:0]   capacity = RST_CAPACITY;
	int                 cur_col = 0;
	int                 cur_row = 0;
	int unsigned        held = 0;
	int                 esc_state = ESC_IDLE;
	logic [COLOR_W-1:0] esc_rgb = '0;
	logic [CH_W-1:0]    esc_digits [HEX_DIGITS];
	screen_op_t         ops_due[$];

	text_console_cursor_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	function automatic int clamp_row(int v);
		if (v > ROW_MAX) return ROW_MAX;
		if (v < ROW_MIN) return ROW_MIN;
		return v;
	endfunction

	function automatic void queue_op(logic kind, int x, int y, logic [CH_W-1:0] g,
			logic [COLOR_W-1:0] fg, int rows);
		screen_op_t op;
		op.kind  = kind;
		op.x     = x[POS_X_W-1:0];
		op.y     = y[ROW_W-1:0];
		op.glyph = g;
		op.fg    = fg;
		op.fill  = bg_reg;
		op.rows  = rows[ROWS_W-1:0];
		op.last  = 1'b0;
		ops_due.push_back(op);
	endfunction

	// carriage return plus line feed, scrolling once at the bottom
	function automatic void line_feed();
		int lh;
		lh = CELL_SIZE + int'(spacing);
		cur_col = 0;
		cur_row = clamp_row(cur_row + lh);
		if (cur_row + CELL_SIZE >= SCREEN_H) begin
			queue_op(KIND_SCROLL, 0, 0, '0, '0, lh);
			cur_row = clamp_row(cur_row - lh);
		end
	endfunction

	function automatic void print_char(logic [CH_W-1:0] c);
		if (c == CH_NL) begin
			line_feed();
			if (held < HELD_MAX) held++;
		end else if (c == CH_BS) begin
			// erase the previous cell, stepping up a row at the left edge
			if (held != 0) begin
				held--;
				cur_col -= CELL_SIZE;
				if (cur_col < 0) begin
					cur_col = SCREEN_W - CELL_SIZE;
					cur_row = clamp_row(cur_row - (CELL_SIZE + int'(spacing)));
				end
				queue_op(KIND_DRAW, cur_col, cur_row, CH_SPACE, fg_now, 0);
			end
		end else if (c != CH_TAB && held < capacity) begin
			held++;
			queue_op(KIND_DRAW, cur_col, cur_row, c, fg_now, 0);
			cur_col += CELL_SIZE;
			if (cur_col + CELL_SIZE >= SCREEN_W) line_feed();
		end
	endfunction

	function automatic int nibble_of(logic [CH_W-1:0] c);
		if (c >= CH_DIG0 && c <= CH_DIG9) return c - CH_DIG0;
		if (c >= CH_LO_A && c <= CH_LO_F) return c - CH_LO_A + 10;
		if (c >= CH_UP_A && c <= CH_UP_F) return c - CH_UP_A + 10;
		return -1;
	endfunction

	// give up a pending escape: lone backslash is drawn, else the
	// backslash is dropped and the paren and digits are replayed
	function automatic void flush_escape();
		int n;
		if (esc_state == ESC_SLASH) begin
			esc_state = ESC_IDLE;
			print_char(CH_BSL);
		end else if (esc_state >= ESC_HEX0) begin
			n = esc_state - ESC_HEX0;
			esc_state = ESC_IDLE;
			print_char(CH_LPAREN);
			for (int i = 0; i < n; i++) print_char(esc_digits[i]);
		end
	endfunction

	function automatic void take_char(logic [CH_W-1:0] c);
		int n;
		int v;
		n = esc_state - ESC_HEX0;
		v = nibble_of(c);
		if (esc_state == ESC_SLASH) begin
			if (c == CH_LPAREN) begin
				esc_state = ESC_HEX0;
				esc_rgb = '0;
				return;
			end
			flush_escape();
		end else if (esc_state >= ESC_HEX0) begin
			if (n < HEX_DIGITS && v >= 0) begin
				esc_digits[n] = c;
				esc_rgb = {esc_rgb[COLOR_W-5:0], v[3:0]};
				esc_state++;
				return;
			end
			if (n == HEX_DIGITS && c == CH_RPAREN) begin
				fg_now = esc_rgb;
				esc_state = ESC_IDLE;
				return;
			end
			flush_escape();
		end
		if (c == CH_BSL) esc_state = ESC_SLASH;
		else print_char(c);
	endfunction

	// one accepted character: queue its commands, flag the last one
	function automatic void advance_console(key_t k);
		int first;
		first = ops_due.size();
		if (k.ch == CH_NUL) begin
			flush_escape();
		end else begin
			take_char(k.ch);
			if (k.eot) flush_escape();
		end
		if (ops_due.size() > first) ops_due[ops_due.size() - 1].last = 1'b1;
	endfunction

	// --------------------------------------------------------- input side

	always @(posedge clk or negedge arst_n) begin : drive_keys
		key_t k;
		logic showing;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			showing = s_tvalid;
			if (s_tvalid && s_tready) begin
				advance_console(key_t'({s_tdata, s_tlast}));
				showing = 1'b0;
				send_gap = steady ? 0 : $urandom_range(0, IDLE_MAX);
			end
			if (!showing) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (typed_keys.size() != 0) begin
					k = typed_keys.pop_front();
					s_tdata <= k.ch;
					s_tlast <= k.eot;
					showing = 1'b1;
				end
			end
			s_tvalid <= showing;
		end
	end

	// -------------------------------------------------------- output side

	task automatic report(string what);
		if (mism_cnt < MSG_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
		mism_cnt++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin : take_ops
		screen_op_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (ops_due.size() == 0) begin
					report("command transfer with nothing expected");
				end else begin
					want = ops_due.pop_front();
					check_field("kind", 32'(m_tuser), 32'(want.kind));
					check_field("pos_x", 32'(m_tdata[9:0]), 32'(want.x));
					check_field("pos_y", 32'(m_tdata[25:10]), 32'(want.y));
					check_field("glyph", 32'(m_tdata[33:26]), 32'(want.glyph));
					check_field("text_color", 32'(m_tdata[57:34]), 32'(want.fg));
					check_field("fill_color", 32'(m_tdata[81:58]), 32'(want.fill));
					check_field("scroll_rows", 32'(m_tdata[90:82]), 32'(want.rows));
					check_field("tdata pad", 32'(m_tdata[TDATA_W-1:91]), '0);
					check_field("run_last", 32'(m_tlast), 32'(want.last));
				end
				recv_gap = steady ? 0 : $urandom_range(0, IDLE_MAX);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !rx_hold;
			end
		end
	end

	// long receiver stall so the engine backs up onto its input
	initial begin : long_stall
		wait (press_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYC) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// ------------------------------------------------------------ stimulus

	task automatic add_key(logic [CH_W-1:0] c, logic eot);
		key_t k;
		k.ch = c;
		k.eot = eot;
		typed_keys.push_back(k);
	endtask

	task automatic add_text(string s, logic eot_last);
		for (int i = 0; i < s.len(); i++) add_key(s[i], eot_last && i == s.len() - 1);
	endtask

	// color escapes, some broken or cut short, plus noise and edits
	task automatic add_random_text(int n);
		int made;
		int pick;
		int cut;
		int sz;
		int nib;
		key_t k;
		made = 0;
		while (made < n) begin
			sz = typed_keys.size();
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, HEX_DIGITS + 1)
					: HEX_DIGITS + 2;
				add_key(CH_BSL, 1'b0);
				for (int pos = 0; pos <= HEX_DIGITS + 1; pos++) begin
					if (pos == cut) begin
						if ($urandom_range(0, 1) != 0) begin
							add_key(CH_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
						end else begin
							// end the string inside the escape
							k = typed_keys.pop_back();
							k.eot = 1'b1;
							typed_keys.push_back(k);
						end
						break;
					end
					if (pos == 0) begin
						add_key(CH_LPAREN, 1'b0);
					end else if (pos <= HEX_DIGITS) begin
						nib = $urandom_range(0, 15);
						if (nib < 10) add_key(CH_W'(CH_DIG0 + nib), 1'b0);
						else if ($urandom_range(0, 1) != 0)
							add_key(CH_W'(CH_UP_A + nib - 10), 1'b0);
						else add_key(CH_W'(CH_LO_A + nib - 10), 1'b0);
					end else begin
						add_key(CH_RPAREN, $urandom_range(0, 7) == 0);
					end
				end
			end else if (pick < 72) begin
				add_key(CH_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else if (pick < 82) begin
				add_key(CH_NL, $urandom_range(0, 7) == 0);
			end else if (pick < 91) begin
				repeat ($urandom_range(1, 4)) add_key(CH_BS, 1'b0);
			end else if (pick < 95) begin
				add_key(CH_TAB, 1'b0);
			end else begin
				// long line to force a wrap at the right edge
				repeat (66) add_key(CH_W'($urandom_range(33, 126)), 1'b0);
			end
			made += typed_keys.size() - sz;
		end
	endtask

	task automatic write_regs(logic [LS_W-1:0] ls, logic [COLOR_W-1:0] bg,
			logic [COLOR_W-1:0] fg, logic [CNT_W-1:0] cap);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_LINE_SPACING;
		cfg_data <= CFG_DATA_W'(ls);
		@(posedge clk);
		cfg_idx  <= CFG_BACKGROUND;
		cfg_data <= bg;
		@(posedge clk);
		cfg_idx  <= CFG_DEFAULT_FG;
		cfg_data <= fg;
		@(posedge clk);
		cfg_idx  <= CFG_CAPACITY;
		cfg_data <= CFG_DATA_W'(cap);
		@(posedge clk);
		cfg_we <= 1'b0;
		spacing  = ls;
		bg_reg   = bg;
		fg_now   = fg;
		capacity = cap;
	endtask

	// wait for every command, then let a trailing silent character finish;
	// sampled mid-cycle so the driver's updates at the edge are settled
	task automatic settle();
		while (typed_keys.size() != 0 || s_tvalid || ops_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty backspace, extremes, controls, escapes of each kind
		add_key(CH_BS, 1'b0);
		add_key(8'hFF, 1'b1);
		add_key(CH_TAB, 1'b0);
		add_key(CH_NL, 1'b0);
		add_key(CH_BS, 1'b0);
		add_text("\\(1aF0b9)", 1'b0);
		add_text("\\Q", 1'b0);
		add_text("\\(7z", 1'b0);
		add_text("\\(e", 1'b1);
		add_text("\\", 1'b1);
		add_key(CH_BSL, 1'b0);
		add_key(CH_NUL, 1'b0);
		settle();

		// zero spacing and colors, with a long output stall
		write_regs(8'd0, 24'h000000, 24'h000000, RST_CAPACITY);
		press_go <= 1'b1;
		add_random_text(40);
		settle();

		// widest spacing, full colors, tiny capacity
		write_regs(8'd255, 24'hFFFFFF, 24'hFFFFFF, 21'd5);
		add_random_text(30);
		settle();

		// no capacity: printables dropped, newline and backspace still act
		write_regs(8'd7, 24'h123456, 24'hA5C3E1, 21'd0);
		add_text("AB\n", 1'b0);
		add_random_text(10);
		settle();

		// random registers, first without idling on either side
		write_regs(LS_W'($urandom_range(0, 255)), COLOR_W'($urandom), COLOR_W'($urandom),
			RST_CAPACITY);
		steady <= 1'b1;
		add_random_text(30);
		settle();
		steady <= 1'b0;
		add_random_text(30);
		settle();

		// reset colors and capacity with widest spacing, then a closing color escape and line
		write_regs(8'd255, RST_BACKGROUND, RST_DEFAULT_FG, RST_CAPACITY);
		add_text("\\(00ff00)ok\n", 1'b1);
		settle();

		if (mism_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
